// ===== hw/rtl/spq_pkg.sv =====
// Shared constants, codes and control types for the sorted priority queue.
// No dependencies; every other file of the block depends on this package.
package spq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int PRI_BITS_DEF  = 16;
  localparam int DATA_BITS_DEF = 32;

  // Operation codes of the input beat
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // capture the input beat and settle status
    logic rd_head;    // read logical slot 0
    logic rd_prev;    // read logical slot k-1
    logic rd_back2;   // read logical slot k-2
    logic shift;      // move the entry just read up to slot k, step k down
    logic place;      // write the new entry at slot k
    logic load_head;  // take the entry just read as the new head
    logic load_out;   // load the result register
  } spq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_insert;
    logic refused;
    logic k_zero;
    logic k_one;
    logic cnt_zero;
    logic prev_gt;
    logic out_busy;
  } spq_sts_t;

endpackage

// ===== hw/rtl/spq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on spq_pkg for default sizes only.
module spq_ram #(
  parameter int WIDTH = spq_pkg::PRI_BITS_DEF + spq_pkg::DATA_BITS_DEF,
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/spq_ctrl.sv =====
// Controller state machine of the sorted priority queue.
// Depends on spq_pkg for the command and status types.
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_sts_t sts,
  output spq_pkg::spq_cmd_t cmd
);

  import spq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_HLD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.refused) begin
          state_nxt = S_OUT;
        end else if (sts.is_insert) begin
          if (sts.k_zero) begin
            state_nxt = S_PLACE;
          end else begin
            cmd.rd_prev = 1'b1;
            state_nxt   = S_CMP;
          end
        end else if (sts.cnt_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.rd_head = 1'b1;
          state_nxt   = S_HLD;
        end
      end
      S_CMP: begin
        if (sts.prev_gt) begin
          cmd.shift = 1'b1;
          if (sts.k_one) begin
            state_nxt = S_PLACE;
          end else begin
            cmd.rd_back2 = 1'b1;
          end
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_OUT;
      end
      S_HLD: begin
        cmd.load_head = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== hw/rtl/spq_dp.sv =====
// Datapath of the sorted priority queue: circular entry store, head copy,
// count and result register. Depends on spq_pkg and spq_ram.
module spq_dp #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int PRI_BITS  = spq_pkg::PRI_BITS_DEF,
  parameter int DATA_BITS = spq_pkg::DATA_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_opcode,
  input  logic signed [PRI_BITS-1:0]   in_item_priority,
  input  logic [DATA_BITS-1:0]         in_item_data,
  input  spq_pkg::spq_cmd_t            cmd,
  output spq_pkg::spq_sts_t            sts,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic                         out_removed_valid,
  output logic signed [PRI_BITS-1:0]   out_removed_priority,
  output logic [DATA_BITS-1:0]         out_removed_data,
  output logic [$clog2(DEPTH+1)-1:0]   out_entry_count,
  output logic                         out_queue_empty,
  output logic signed [PRI_BITS-1:0]   out_head_priority,
  output logic [DATA_BITS-1:0]         out_head_data
);

  import spq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = PRI_BITS + DATA_BITS;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Add an offset to a slot address, wrapping at DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  logic [CW-1:0]              count_r, count_nxt;
  logic [AW-1:0]              head_ptr_r, head_ptr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [AW-1:0]              k_r;
  logic                       op_r;
  logic signed [PRI_BITS-1:0] new_pri_r;
  logic [DATA_BITS-1:0]       new_data_r;
  logic [1:0]                 res_status_r;
  logic                       res_rvalid_r;
  logic [PRI_BITS-1:0]        res_rpri_r;
  logic [DATA_BITS-1:0]       res_rdata_r;
  logic [PRI_BITS-1:0]        hd_pri_r;
  logic [DATA_BITS-1:0]       hd_data_r;
  logic                       full;

  logic [AW-1:0]              rd_idx;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [EW-1:0]              ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [EW-1:0]              ram_rdata;
  logic signed [PRI_BITS-1:0] rd_pri;

  assign full = (count_r == DEPTH_C);

  // Store addressing: logical slot 0 sits at head_ptr_r
  always_comb begin
    if (cmd.rd_head) begin
      rd_idx = '0;
    end else if (cmd.rd_back2) begin
      rd_idx = k_r - AW'(1) - AW'(1);
    end else begin
      rd_idx = k_r - AW'(1);
    end
  end

  assign ram_raddr = wrap_add(head_ptr_r, rd_idx);
  assign ram_waddr = wrap_add(head_ptr_r, k_r);
  assign ram_we    = cmd.shift | cmd.place;
  assign ram_wdata = cmd.shift ? ram_rdata : {new_pri_r, new_data_r};
  assign rd_pri    = ram_rdata[EW-1:DATA_BITS];

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    count_nxt     = count_r;
    head_ptr_nxt  = head_ptr_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.accept) begin
      if (in_opcode == OP_INSERT) begin
        if (!full) begin
          count_nxt = count_r + CW'(1);
        end
      end else if (count_r != '0) begin
        count_nxt    = count_r - CW'(1);
        head_ptr_nxt = wrap_add(head_ptr_r, AW'(1));
      end
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      head_ptr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      head_ptr_r  <= head_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item capture and status settle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r         <= in_opcode;
      new_pri_r    <= in_item_priority;
      new_data_r   <= in_item_data;
      k_r          <= count_r[AW-1:0];
      res_status_r <= ST_OK;
      res_rvalid_r <= 1'b0;
      res_rpri_r   <= '0;
      res_rdata_r  <= '0;
      if (in_opcode == OP_INSERT) begin
        if (full) begin
          res_status_r <= ST_FULL;
        end
      end else if (count_r == '0) begin
        res_status_r <= ST_EMPTY;
      end else begin
        res_rvalid_r <= 1'b1;
        res_rpri_r   <= hd_pri_r;
        res_rdata_r  <= hd_data_r;
      end
    end else if (cmd.shift) begin
      k_r <= k_r - AW'(1);
    end
  end

  // Head copy: refresh on placement at slot 0 or after a remove
  always_ff @(posedge clk) begin
    if (cmd.place && (k_r == '0)) begin
      hd_pri_r  <= new_pri_r;
      hd_data_r <= new_data_r;
    end else if (cmd.load_head) begin
      hd_pri_r  <= ram_rdata[EW-1:DATA_BITS];
      hd_data_r <= ram_rdata[DATA_BITS-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status           <= res_status_r;
      out_removed_valid    <= res_rvalid_r;
      out_removed_priority <= res_rpri_r;
      out_removed_data     <= res_rdata_r;
      out_entry_count      <= count_r;
      out_queue_empty      <= (count_r == '0);
      out_head_priority    <= (count_r == '0) ? '0 : hd_pri_r;
      out_head_data        <= (count_r == '0) ? '0 : hd_data_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts.is_insert = (op_r == OP_INSERT);
    sts.refused   = (res_status_r != ST_OK);
    sts.k_zero    = (k_r == '0);
    sts.k_one     = (k_r == AW'(1));
    sts.cnt_zero  = (count_r == '0);
    sts.prev_gt   = (rd_pri > new_pri_r);
    sts.out_busy  = out_valid_r && out_stall;
  end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl, spq_dp (and through it spq_ram).
//
// Usage
//   Input channel (in_*): one beat is one operation. in_opcode selects insert
//   or remove of the head; priority and data matter for insert only.
//   Result channel (out_*): exactly one beat per input beat, in order: status,
//   the removed entry (zero on insert or refusal), count, empty flag and the
//   head after the operation (zero when empty).
//   Entries sit sorted in a circular RAM store; smaller priority leaves first,
//   equal priorities leave in arrival order.
// Sequencing
//   One beat at a time; the input stays closed from accept until the result is
//   loaded. An insert moves every entry of larger priority up one slot, one at
//   a time on the single RAM write port, before it places the new entry.
// Reset
//   rst_n (synchronous) empties the queue; the store itself needs no clearing.
// Stalls
//   The result register holds while out_stall is high; a new beat is taken
//   meanwhile and its result waits, with the input closed, until the register frees.
module sorted_priority_queue #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int PRI_BITS  = spq_pkg::PRI_BITS_DEF,
  parameter int DATA_BITS = spq_pkg::DATA_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic signed [PRI_BITS-1:0]   in_item_priority,
  input  logic [DATA_BITS-1:0]         in_item_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic                         out_removed_valid,
  output logic signed [PRI_BITS-1:0]   out_removed_priority,
  output logic [DATA_BITS-1:0]         out_removed_data,
  output logic [$clog2(DEPTH+1)-1:0]   out_entry_count,
  output logic                         out_queue_empty,
  output logic signed [PRI_BITS-1:0]   out_head_priority,
  output logic [DATA_BITS-1:0]         out_head_data
);

  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  spq_cmd_t cmd;
  spq_sts_t sts;

  // Sequence each operation: capture, walk the store, load the result
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the entries, the count and the result register
  spq_dp #(
    .DEPTH     (DEPTH),
    .PRI_BITS  (PRI_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_opcode            (in_opcode),
    .in_item_priority     (in_item_priority),
    .in_item_data         (in_item_data),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_removed_valid    (out_removed_valid),
    .out_removed_priority (out_removed_priority),
    .out_removed_data     (out_removed_data),
    .out_entry_count      (out_entry_count),
    .out_queue_empty      (out_queue_empty),
    .out_head_priority    (out_head_priority),
    .out_head_data        (out_head_data)
  );

  // One operation in flight: an accepted beat closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an operation was in flight");

  // An empty queue reports a zero head
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_queue_empty) |->
      (out_head_priority == '0 && out_head_data == '0 && out_entry_count == '0))
    else $error("empty result carries a head entry");

  // A removed entry only comes with an ok status
  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_removed_valid) |-> (out_status == ST_OK))
    else $error("removed entry reported with a failing status");

  // A refused insert only happens at full count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_entry_count == CW'(DEPTH)))
    else $error("insert refused below full count");

endmodule
